// File: design/csdem_pkg.sv
// Shared constants, types and state codes for the CAN signal decode and event match unit.
`timescale 1ns / 1ps
package csdem_pkg;

	// Table geometry.
	localparam int MESSAGE_SLOTS       = 16;
	localparam int SIGNALS_PER_MESSAGE = 8;
	localparam int EVENTS_PER_SIGNAL   = 4;
	localparam int FRAME_BYTES         = 8;
	localparam int SIG_TOTAL           = MESSAGE_SLOTS * SIGNALS_PER_MESSAGE;
	localparam int EVT_TOTAL           = SIG_TOTAL * EVENTS_PER_SIGNAL;
	localparam int MSG_IDX_W           = $clog2(MESSAGE_SLOTS);
	localparam int SIG_IDX_W           = $clog2(SIGNALS_PER_MESSAGE);
	localparam int EVT_IDX_W           = $clog2(EVENTS_PER_SIGNAL);
	localparam int SIG_ADDR_W          = MSG_IDX_W + SIG_IDX_W;
	localparam int EVT_ADDR_W          = SIG_ADDR_W + EVT_IDX_W;

	// Equal rule tolerance in Q16 LSBs.
	localparam int EQUAL_TOLERANCE = 66;

	// Stream widths.
	localparam int IN_DATA_W  = 232;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_W      = 5;

	// Input tdata field positions, lowest bit first.
	localparam int ID_LO     = 0;
	localparam int PAY_LO    = 29;
	localparam int PLEN_LO   = 93;
	localparam int MSLOT_LO  = 97;
	localparam int SSLOT_LO  = 101;
	localparam int ESLOT_LO  = 104;
	localparam int CNT_LO    = 106;
	localparam int LAYOUT_LO = 110;
	localparam int GAIN_LO   = 124;
	localparam int OFF_LO    = 156;
	localparam int RULE_LO   = 220;

	// Operation codes carried in s_tuser.
	localparam logic [1:0] OP_FRAME     = 2'd0;
	localparam logic [1:0] OP_WR_MSG    = 2'd1;
	localparam logic [1:0] OP_WR_SIGNAL = 2'd2;
	localparam logic [1:0] OP_WR_EVENT  = 2'd3;

	// Event rule conditions.
	localparam logic [1:0] COND_EQUAL   = 2'd0;
	localparam logic [1:0] COND_GREATER = 2'd1;
	localparam logic [1:0] COND_LESS    = 2'd2;
	localparam logic [1:0] COND_NEVER   = 2'd3;

	// One signal table entry.
	typedef struct packed {
		logic [2:0]  evt_count;
		logic [63:0] offset;
		logic [31:0] gain;
		logic [13:0] layout;
	} sig_entry_t;

	// One event table entry.
	typedef struct packed {
		logic [63:0] threshold;
		logic [9:0]  rule;
	} evt_entry_t;

	// Frame sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SIG_RD,
		ST_EXTRACT,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_SAT,
		ST_EVT_RD,
		ST_EVT_TEST,
		ST_SUMMARY
	} state_t;

endpackage

// File: design/can_signal_decode_event_match_unit.sv
// Top level: table-driven CAN signal decoder with event rule matching.
`timescale 1ns / 1ps
// Usage
// Input items arrive on the s_ stream; s_tuser carries the operation. Write
// operations load the message, signal or event tables in the accepting cycle
// and produce no output, so the next item can follow in the next cycle. A frame
// transaction is searched against the first slots of the search window, one
// slot per cycle. Each signal of the hit then steps through signal memory read,
// extract, two partial products, offset add and saturate, then an event memory
// read and a test for each event rule, then a rule loop exit. s_tready is high
// only while no frame is in progress, so it returns in the cycle after the
// summary is loaded. Each fired rule leaves as one m_ transaction with m_tuser
// high, loaded into the output register by its test; a summary transaction
// with m_tlast high closes every frame. If the receiver holds m_tready low, the
// sequencer waits with the next result until the output register drains.
// The search window size is written on the cfg_ channel. Reset clears the
// sequencer, the output register and the window size; the tables hold no
// defined value until they are written.
module can_signal_decode_event_match_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: number of message slots searched.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csdem_pkg::CFG_W-1:0]       cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// frame_id, payload, payload_length, message_slot, signal_slot,
	// event_slot, entry_count, signal_layout, scale_factor,
	// offset_or_threshold, event_rule, zero fill
	input  logic [csdem_pkg::IN_DATA_W-1:0]   s_tdata,
	// operation
	input  logic [csdem_pkg::IN_USER_W-1:0]   s_tuser,
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_code, message_matched, any_decoded, zero fill
	output logic [csdem_pkg::OUT_DATA_W-1:0]  m_tdata,
	// event_fired
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);
	import csdem_pkg::*;

	// Input field views.
	logic [28:0]  in_id;
	logic [63:0]  in_payload;
	logic [3:0]   in_plen;
	logic [3:0]   in_mslot;
	logic [2:0]   in_sslot;
	logic [1:0]   in_eslot;
	logic [3:0]   in_cnt;
	logic [13:0]  in_layout;
	logic [31:0]  in_gain;
	logic [63:0]  in_offthr;
	logic [9:0]   in_rule;

	assign in_id      = s_tdata[ID_LO +: 29];
	assign in_payload = s_tdata[PAY_LO +: 64];
	assign in_plen    = s_tdata[PLEN_LO +: 4];
	assign in_mslot   = s_tdata[MSLOT_LO +: 4];
	assign in_sslot   = s_tdata[SSLOT_LO +: 3];
	assign in_eslot   = s_tdata[ESLOT_LO +: 2];
	assign in_cnt     = s_tdata[CNT_LO +: 4];
	assign in_layout  = s_tdata[LAYOUT_LO +: 14];
	assign in_gain    = s_tdata[GAIN_LO +: 32];
	assign in_offthr  = s_tdata[OFF_LO +: 64];
	assign in_rule    = s_tdata[RULE_LO +: 10];

	state_t state_q, state_d;

	logic        in_acc;
	logic [4:0]  msg_count_q;
	logic [28:0] frame_id_q;
	logic [63:0] payload_q;
	logic [3:0]  plen_q;
	logic [4:0]  limit_q;
	logic [4:0]  idx_q;
	logic [MSG_IDX_W-1:0] hit_q;
	logic [3:0]  sig_cnt_q;
	logic [3:0]  sig_i_q;
	logic [2:0]  evt_j_q;
	logic        found_q;
	logic        any_q;

	// Message table: small register file, scanned one slot per cycle.
	logic [28:0] msg_id_q  [MESSAGE_SLOTS];
	logic [3:0]  msg_cnt_q [MESSAGE_SLOTS];

	// Signal and event memories, synchronous read.
	sig_entry_t sig_mem [SIG_TOTAL];
	evt_entry_t evt_mem [EVT_TOTAL];
	sig_entry_t sig_rd_q;
	evt_entry_t evt_rd_q;

	// Datapath registers.
	logic [63:0]        raw_q;
	logic               neg_q;
	logic signed [64:0] p_lo_q;
	logic signed [64:0] p_hi_q;
	logic signed [65:0] acc_q;
	logic signed [63:0] value_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_code_q;
	logic       out_fired_q;
	logic       out_matched_q;
	logic       out_any_q;
	logic       out_last_q;

	// Sequencer controls.
	logic slot_hit;
	logic out_free;
	logic out_load;
	logic out_is_event;
	logic sig_rd_en;
	logic evt_rd_en;
	logic search_step;
	logic sig_step;
	logic evt_step;
	logic fire;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign slot_hit  = (msg_id_q[idx_q[MSG_IDX_W-1:0]] == frame_id_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			msg_count_q <= cfg_data;
		end
	end

	// Message table writes.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_WR_MSG) begin
			msg_id_q[in_mslot]  <= in_id;
			msg_cnt_q[in_mslot] <= (in_cnt > 4'(SIGNALS_PER_MESSAGE))
				? 4'(SIGNALS_PER_MESSAGE) : in_cnt;
		end
	end

	// Signal memory: write on a signal write transaction, read by the sequencer.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_WR_SIGNAL) begin
			sig_mem[{in_mslot, in_sslot}] <= '{
				evt_count: (in_cnt > 4'(EVENTS_PER_SIGNAL))
					? 3'(EVENTS_PER_SIGNAL) : in_cnt[2:0],
				offset: in_offthr,
				gain: in_gain,
				layout: in_layout
			};
		end
		if (sig_rd_en) begin
			sig_rd_q <= sig_mem[{hit_q, sig_i_q[SIG_IDX_W-1:0]}];
		end
	end

	// Event memory: write on an event write transaction, read by the sequencer.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_WR_EVENT) begin
			evt_mem[{in_mslot, in_sslot, in_eslot}] <= '{threshold: in_offthr, rule: in_rule};
		end
		if (evt_rd_en) begin
			evt_rd_q <= evt_mem[{hit_q, sig_i_q[SIG_IDX_W-1:0], evt_j_q[EVT_IDX_W-1:0]}];
		end
	end

	function automatic logic [63:0] in_payload_mask(input logic [63:0] p, input logic [63:0] m);
		return p & m;
	endfunction

	// Bit extraction with payload length limit and sign extension.
	logic [5:0]  ex_start;
	logic [5:0]  ex_lenm1;
	logic [63:0] ex_valid;
	logic [63:0] ex_lenmask;
	logic [63:0] ex_upto;
	logic [63:0] ex_pm;
	logic [6:0]  ex_shift;
	logic [6:0]  ex_nshift;
	logic [63:0] ex_raw;
	logic        ex_neg;
	logic        ex_beyond;

	always_comb begin
		ex_start   = sig_rd_q.layout[5:0];
		ex_lenm1   = sig_rd_q.layout[11:6];
		for (int k = 0; k < 8; k++) begin
			ex_valid[8*k +: 8] = (4'(k) < plen_q) ? 8'hFF : 8'h00;
		end
		// The start bit itself lies outside the valid bytes.
		ex_beyond  = ({1'b0, ex_start[5:3]} >= plen_q);
		ex_lenmask = {64{1'b1}} >> (6'd63 - ex_lenm1);
		ex_upto    = {64{1'b1}} >> (6'd63 - ex_start);
		ex_shift   = {1'b0, ex_lenm1} - {1'b0, ex_start};
		ex_nshift  = 7'd0 - ex_shift;
		if (sig_rd_q.layout[12]) begin
			// Big endian: bits run downward from the start bit, and nothing is
			// taken when the start bit is already past the valid bytes.
			ex_pm = ex_beyond ? 64'd0 : (in_payload_mask(payload_q, ex_valid) & ex_upto);
			if (!ex_shift[6]) begin
				ex_raw = (ex_pm << ex_shift[5:0]) & ex_lenmask;
			end else begin
				ex_raw = (ex_pm >> ex_nshift[5:0]) & ex_lenmask;
			end
		end else begin
			ex_pm  = in_payload_mask(payload_q, ex_valid);
			ex_raw = (ex_pm >> ex_start) & ex_lenmask;
		end
		ex_neg = sig_rd_q.layout[13] && (ex_lenm1 != 6'd63) && ex_raw[ex_lenm1];
		if (ex_neg) begin
			ex_raw = ex_raw | ~ex_lenmask;
		end
	end

	// Final sum and saturation.
	logic signed [97:0] sat_sum;
	logic signed [63:0] sat_val;

	always_comb begin
		sat_sum = (98'(p_hi_q) <<< 32) + 98'(acc_q);
		if (sat_sum[97:63] == {35{1'b0}} || sat_sum[97:63] == {35{1'b1}}) begin
			sat_val = sat_sum[63:0];
		end else if (sat_sum[97]) begin
			sat_val = {1'b1, {63{1'b0}}};
		end else begin
			sat_val = {1'b0, {63{1'b1}}};
		end
	end

	// Event rule test.
	logic signed [64:0] ev_diff;
	logic signed [63:0] ev_thr;

	always_comb begin
		ev_thr  = evt_rd_q.threshold;
		ev_diff = 65'(value_q) - 65'(ev_thr);
		case (evt_rd_q.rule[1:0])
			COND_EQUAL:   fire = (ev_diff < 65'sd66) && (ev_diff > -65'sd66);
			COND_GREATER: fire = value_q > ev_thr;
			COND_LESS:    fire = value_q < ev_thr;
			COND_NEVER:   fire = 1'b0;
			default:      fire = 1'b0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer controls.
	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		out_is_event = 1'b0;
		sig_rd_en    = 1'b0;
		evt_rd_en    = 1'b0;
		search_step  = 1'b0;
		sig_step     = 1'b0;
		evt_step     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == OP_FRAME) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (idx_q >= limit_q) begin
					state_d = ST_SUMMARY;
				end else if (slot_hit) begin
					state_d = ST_SIG_RD;
				end else begin
					search_step = 1'b1;
				end
			end
			ST_SIG_RD: begin
				if (sig_i_q >= sig_cnt_q) begin
					state_d = ST_SUMMARY;
				end else begin
					sig_rd_en = 1'b1;
					state_d   = ST_EXTRACT;
				end
			end
			ST_EXTRACT: state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_ACC;
			ST_ACC:     state_d = ST_SAT;
			ST_SAT:     state_d = ST_EVT_RD;
			ST_EVT_RD: begin
				if (evt_j_q >= sig_rd_q.evt_count) begin
					sig_step = 1'b1;
					state_d  = ST_SIG_RD;
				end else begin
					evt_rd_en = 1'b1;
					state_d   = ST_EVT_TEST;
				end
			end
			ST_EVT_TEST: begin
				if (!fire) begin
					evt_step = 1'b1;
					state_d  = ST_EVT_RD;
				end else if (out_free) begin
					out_load     = 1'b1;
					out_is_event = 1'b1;
					evt_step     = 1'b1;
					state_d      = ST_EVT_RD;
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Frame control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sig_i_q <= '0;
			evt_j_q <= '0;
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			if (in_acc && s_tuser == OP_FRAME) begin
				idx_q   <= '0;
				sig_i_q <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end
			if (search_step) begin
				idx_q <= idx_q + 5'd1;
			end
			if (state_q == ST_SEARCH && idx_q < limit_q && slot_hit) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_SAT) begin
				evt_j_q <= '0;
			end
			if (sig_step) begin
				sig_i_q <= sig_i_q + 4'd1;
			end
			if (evt_step) begin
				evt_j_q <= evt_j_q + 3'd1;
			end
			if (out_load && out_is_event) begin
				any_q <= 1'b1;
			end
		end
	end

	// Frame payload registers.
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_FRAME) begin
			frame_id_q <= in_id;
			payload_q  <= in_payload;
			plen_q     <= (in_plen > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : in_plen;
			limit_q    <= (msg_count_q > 5'(MESSAGE_SLOTS)) ? 5'(MESSAGE_SLOTS) : msg_count_q;
		end
		if (state_q == ST_SEARCH && idx_q < limit_q && slot_hit) begin
			hit_q     <= idx_q[MSG_IDX_W-1:0];
			sig_cnt_q <= msg_cnt_q[idx_q[MSG_IDX_W-1:0]];
		end
	end

	// Scaling datapath: extract, two partial products, offset add, saturate.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EXTRACT: begin
				raw_q <= ex_raw;
				neg_q <= ex_neg;
			end
			ST_MUL_LO: begin
				p_lo_q <= $signed({1'b0, raw_q[31:0]}) * $signed(sig_rd_q.gain);
			end
			ST_MUL_HI: begin
				p_hi_q <= $signed({neg_q, raw_q[63:32]}) * $signed(sig_rd_q.gain);
			end
			ST_ACC: begin
				acc_q <= 66'(p_lo_q) + 66'($signed(sig_rd_q.offset));
			end
			ST_SAT: begin
				value_q <= sat_val;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q    <= out_is_event ? evt_rd_q.rule[9:2] : 8'd0;
			out_fired_q   <= out_is_event;
			out_matched_q <= out_is_event || found_q;
			out_any_q     <= out_is_event || any_q;
			out_last_q    <= !out_is_event;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_any_q, out_matched_q, out_code_q};
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// An event can only fire for a frame whose identifier was found.
	assert property (@(posedge clk) disable iff (!arst_n) any_q |-> found_q)
		else $error("event flagged without a matching message");

	// The search index never runs past the slot limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> idx_q <= limit_q)
		else $error("search index beyond limit");

	// An event rule is tested only inside the signal's rule count.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVT_TEST |-> evt_j_q < sig_rd_q.evt_count)
		else $error("event index beyond rule count");

	// A held result is not overwritten while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !out_load)
		else $error("output overwritten during stall");
`endif

endmodule

// File: test/can_signal_decode_event_match_unit_tb.sv
// Self-checking testbench for the CAN signal decode and event match unit.
`timescale 1ns / 1ps
module can_signal_decode_event_match_unit_tb;
	import csdem_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	// One input item, unpacked.
	typedef struct {
		logic [1:0]  op;
		logic [28:0] id;
		logic [63:0] payload;
		logic [3:0]  plen;
		logic [3:0]  mslot;
		logic [2:0]  sslot;
		logic [1:0]  eslot;
		logic [3:0]  count;
		logic [13:0] layout;
		logic [31:0] gain;
		logic [63:0] offthr;
		logic [9:0]  rule;
	} can_item_t;

	// One decoded result.
	typedef struct {
		logic [7:0] code;
		logic       fired;
		logic       matched;
		logic       any;
		logic       last;
	} decode_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tlast;

	can_signal_decode_event_match_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Shadow copy of the block's tables and register.
	logic [4:0]         search_count = '0;
	logic [28:0]        slot_id    [MESSAGE_SLOTS];
	logic [3:0]         slot_nsig  [MESSAGE_SLOTS];
	logic [13:0]        sig_layout [SIG_TOTAL];
	logic signed [31:0] sig_gain   [SIG_TOTAL];
	logic signed [63:0] sig_offset [SIG_TOTAL];
	logic [2:0]         sig_nevt   [SIG_TOTAL];
	logic [9:0]         evt_rule   [EVT_TOTAL];
	logic signed [63:0] evt_thresh [EVT_TOTAL];
	bit                 slot_loaded[MESSAGE_SLOTS];
	bit                 sig_loaded [SIG_TOTAL];
	bit                 evt_loaded [EVT_TOTAL];

	decode_result_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int events_seen = 0;
	int cycles = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_wait = 0;
	int rx_hold = 0;

	// Clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: per-result random stall, plus an optional long hold-off.
	always @(posedge clk) begin
		decode_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0])
				events_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: code %0d fired %0b last %0b",
					m_tdata[7:0], m_tuser[0], m_tlast);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.code) begin
					$error("event_code expected %0d actual %0d", want.code, m_tdata[7:0]);
					errors++;
				end
				if (m_tuser[0] !== want.fired) begin
					$error("event_fired expected %0b actual %0b", want.fired, m_tuser[0]);
					errors++;
				end
				if (m_tdata[8] !== want.matched) begin
					$error("message_matched expected %0b actual %0b", want.matched,
						m_tdata[8]);
					errors++;
				end
				if (m_tdata[9] !== want.any) begin
					$error("any_decoded expected %0b actual %0b", want.any, m_tdata[9]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last expected %0b actual %0b", want.last, m_tlast);
					errors++;
				end
			end
			rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Work out the results of one frame from the shadow tables.
	function automatic void predict_frame(can_item_t it);
		int limit, hit, nsig, nevt, nbytes, start, len, b, si, ei;
		bit found, big, sgn, neg, fire, any;
		logic [63:0] raw;
		logic signed [129:0] acc, max_val, min_val;
		logic signed [63:0] value, thr;
		logic signed [64:0] diff;
		decode_result_t r;
		found = 1'b0;
		any = 1'b0;
		hit = 0;
		max_val = {66'd0, 64'h7FFF_FFFF_FFFF_FFFF};
		min_val = {{66{1'b1}}, 64'h8000_0000_0000_0000};
		nbytes = (it.plen > FRAME_BYTES) ? FRAME_BYTES : it.plen;
		limit = (search_count > MESSAGE_SLOTS) ? MESSAGE_SLOTS : search_count;
		for (int i = 0; i < limit && !found; i++) begin
			if (slot_id[i] == it.id) begin
				found = 1'b1;
				hit = i;
			end
		end
		if (found) begin
			nsig = (slot_nsig[hit] > SIGNALS_PER_MESSAGE) ? SIGNALS_PER_MESSAGE
				: slot_nsig[hit];
			for (int s = 0; s < nsig; s++) begin
				si = hit * SIGNALS_PER_MESSAGE + s;
				start = sig_layout[si][5:0];
				len = sig_layout[si][11:6] + 1;
				big = sig_layout[si][12];
				sgn = sig_layout[si][13];
				raw = '0;
				// Pull bits until the signal or the valid bytes run out.
				for (int i = 0; i < len; i++) begin
					if (big && i > start)
						break;
					b = big ? start - i : start + i;
					if (b >= nbytes * 8)
						break;
					if (it.payload[b])
						raw[big ? len - 1 - i : i] = 1'b1;
				end
				neg = sgn && len < 64 && raw[len - 1];
				if (neg)
					raw = raw | ~((64'd1 << len) - 64'd1);
				// Exact multiply-add, then saturate to 64 bits.
				acc = $signed({{66{neg}}, raw}) * $signed({{98{sig_gain[si][31]}}, sig_gain[si]})
					+ $signed({{66{sig_offset[si][63]}}, sig_offset[si]});
				if (acc > max_val)
					value = 64'sh7FFF_FFFF_FFFF_FFFF;
				else if (acc < min_val)
					value = 64'sh8000_0000_0000_0000;
				else
					value = acc[63:0];
				nevt = (sig_nevt[si] > EVENTS_PER_SIGNAL) ? EVENTS_PER_SIGNAL : sig_nevt[si];
				for (int e = 0; e < nevt; e++) begin
					ei = si * EVENTS_PER_SIGNAL + e;
					thr = evt_thresh[ei];
					diff = {value[63], value} - {thr[63], thr};
					case (evt_rule[ei][1:0])
						COND_EQUAL:   fire = diff < EQUAL_TOLERANCE && diff > -EQUAL_TOLERANCE;
						COND_GREATER: fire = value > thr;
						COND_LESS:    fire = value < thr;
						default:      fire = 1'b0;
					endcase
					if (fire) begin
						r = '{code: evt_rule[ei][9:2], fired: 1'b1, matched: 1'b1,
							any: 1'b1, last: 1'b0};
						pending_results.push_back(r);
						any = 1'b1;
					end
				end
			end
		end
		r = '{code: 8'd0, fired: 1'b0, matched: found, any: any, last: 1'b1};
		pending_results.push_back(r);
	endfunction

	// Apply one accepted item to the shadow state.
	function automatic void apply_item(can_item_t it);
		int si, ei;
		si = it.mslot * SIGNALS_PER_MESSAGE + it.sslot;
		ei = si * EVENTS_PER_SIGNAL + it.eslot;
		case (it.op)
			OP_FRAME: predict_frame(it);
			OP_WR_MSG: begin
				slot_id[it.mslot] = it.id;
				slot_nsig[it.mslot] = (it.count > SIGNALS_PER_MESSAGE)
					? 4'(SIGNALS_PER_MESSAGE) : it.count;
				slot_loaded[it.mslot] = 1'b1;
			end
			OP_WR_SIGNAL: begin
				sig_layout[si] = it.layout;
				sig_gain[si] = it.gain;
				sig_offset[si] = it.offthr;
				sig_nevt[si] = (it.count > EVENTS_PER_SIGNAL)
					? 3'(EVENTS_PER_SIGNAL) : it.count[2:0];
				sig_loaded[si] = 1'b1;
			end
			default: begin
				evt_rule[ei] = it.rule;
				evt_thresh[ei] = it.offthr;
				evt_loaded[ei] = 1'b1;
			end
		endcase
	endfunction

	// Gain drawn from full range, a small range around zero, exactly unity, or zero.
	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
			2:       return 32'h0001_0000;
			default: return 32'd0;
		endcase
	endfunction

	// Offset or threshold drawn from full range, small values, or zero.
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return {$urandom, $urandom};
			1:       return 64'($signed({32'd0, $urandom_range(0, 32'h0400_0000)})
				- 64'sh0200_0000);
			2:       return 64'($signed({32'd0, $urandom_range(0, 200)}) - 64'sd100);
			default: return 64'd0;
		endcase
	endfunction

	function automatic can_item_t random_item();
		can_item_t it;
		it.op = 2'($urandom);
		it.id = 29'($urandom);
		it.payload = {$urandom, $urandom};
		it.plen = 4'($urandom);
		it.mslot = 4'($urandom);
		it.sslot = 3'($urandom);
		it.eslot = 2'($urandom);
		it.count = 4'($urandom);
		it.layout = 14'($urandom);
		it.gain = $urandom;
		it.offthr = {$urandom, $urandom};
		it.rule = 10'($urandom);
		return it;
	endfunction

	// Offer one item after a random gap and wait for its transaction.
	task automatic send_item(can_item_t it);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b00, it.rule, it.offthr, it.gain, it.layout, it.count, it.eslot,
			it.sslot, it.mslot, it.plen, it.payload, it.id};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (it.op == OP_FRAME)
			frames_sent++;
		apply_item(it);
	endtask

	task automatic release_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending until every expected result has come back.
	task automatic drain();
		release_input();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_event(int ms, int ss, int es, logic [9:0] rule, logic [63:0] thr);
		can_item_t it;
		it = random_item();
		it.op = OP_WR_EVENT;
		it.mslot = 4'(ms);
		it.sslot = 3'(ss);
		it.eslot = 2'(es);
		it.rule = rule;
		it.offthr = thr;
		send_item(it);
	endtask

	// Signal write; any event it enables that was never loaded is loaded first.
	task automatic write_signal(int ms, int ss, logic [13:0] layout, logic [31:0] gain,
			logic [63:0] offset, logic [3:0] nevt);
		can_item_t it;
		int si;
		si = ms * SIGNALS_PER_MESSAGE + ss;
		for (int e = 0; e < nevt && e < EVENTS_PER_SIGNAL; e++)
			if (!evt_loaded[si * EVENTS_PER_SIGNAL + e])
				write_event(ms, ss, e, 10'($urandom), pick_value());
		it = random_item();
		it.op = OP_WR_SIGNAL;
		it.mslot = 4'(ms);
		it.sslot = 3'(ss);
		it.layout = layout;
		it.gain = gain;
		it.offthr = offset;
		it.count = nevt;
		send_item(it);
	endtask

	task automatic write_random_signal(int ms, int ss);
		write_signal(ms, ss, 14'($urandom), pick_gain(), pick_value(),
			4'($urandom_range(0, 15)));
	endtask

	// Message write; any signal it enables that was never loaded is loaded first.
	task automatic write_message(int ms, logic [28:0] id, logic [3:0] nsig);
		can_item_t it;
		for (int s = 0; s < nsig && s < SIGNALS_PER_MESSAGE; s++)
			if (!sig_loaded[ms * SIGNALS_PER_MESSAGE + s])
				write_random_signal(ms, s);
		it = random_item();
		it.op = OP_WR_MSG;
		it.mslot = 4'(ms);
		it.id = id;
		it.count = nsig;
		send_item(it);
	endtask

	task automatic send_frame(logic [28:0] id, logic [63:0] payload, logic [3:0] plen);
		can_item_t it;
		it = random_item();
		it.op = OP_FRAME;
		it.id = id;
		it.payload = payload;
		it.plen = plen;
		send_item(it);
	endtask

	// Register write, only with the block idle.
	task automatic set_search_count(logic [4:0] value);
		drain();
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		search_count = value;
	endtask

	// Frames with an empty search window only produce the summary.
	task automatic test_empty_table();
		send_frame(29'h0, 64'h0, 4'd8);
		send_frame(29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		set_search_count(5'd0);
	endtask

	// Load every message slot so that any search window is defined.
	task automatic test_table_load();
		for (int m = 0; m < MESSAGE_SLOTS; m++)
			write_message(m, 29'(32'h100 + m), 4'd0);
		set_search_count(5'd16);
	endtask

	// Hand-built layouts covering byte order, sign, saturation and every condition.
	task automatic test_directed_decode();
		// Little endian unsigned byte zero, unity gain.
		write_event(0, 0, 0, {8'd1, COND_EQUAL}, 64'h005A_0000);
		write_event(0, 0, 1, {8'd2, COND_GREATER}, 64'd0);
		write_event(0, 0, 2, {8'd3, COND_LESS}, 64'd0);
		write_event(0, 0, 3, {8'd4, COND_NEVER}, 64'd0);
		write_signal(0, 0, {2'b00, 6'd7, 6'd0}, 32'h0001_0000, 64'd0, 4'd4);
		// Big endian signed 12 bits from bit 7, negative gain.
		write_event(0, 1, 0, {8'hFF, COND_GREATER}, 64'd0);
		write_event(0, 1, 1, {8'h00, COND_LESS}, 64'd0);
		write_signal(0, 1, {2'b11, 6'd11, 6'd7}, 32'hFFFF_0000, 64'd0, 4'd2);
		// Full 64 bit signed field, extreme gain and offset to force saturation.
		write_event(0, 2, 0, {8'd5, COND_GREATER}, 64'h7FFF_FFFF_FFFF_FFFE);
		write_event(0, 2, 1, {8'd6, COND_LESS}, 64'h8000_0000_0000_0001);
		write_event(0, 2, 2, {8'd7, COND_EQUAL}, 64'h7FFF_FFFF_FFFF_FFFF);
		write_event(0, 2, 3, {8'd8, COND_NEVER}, 64'd0);
		write_signal(0, 2, {2'b10, 6'd63, 6'd0}, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
			4'd15);
		write_message(0, 29'h0ABC_DEF0, 4'd3);
		// Same id again further up: the lower slot must win.
		write_message(1, 29'h0ABC_DEF0, 4'd0);
		// Oversized signal count.
		write_message(5, 29'h1FFF_FFFF, 4'd15);
		send_frame(29'h0ABC_DEF0, 64'h0000_0000_0000_805A, 4'd8);
		send_frame(29'h0ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_frame(29'h0ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
		send_frame(29'h0ABC_DEF0, 64'h8000_0000_0000_00FF, 4'd1);
		send_frame(29'h0ABC_DEF0, 64'h8000_0000_0000_0000, 4'd15);
		send_frame(29'h1FFF_FFFF, {$urandom, $urandom}, 4'd8);
		send_frame(29'h0000_0123, {$urandom, $urandom}, 4'd8);
		set_search_count(5'd1);
		send_frame(29'h1FFF_FFFF, {$urandom, $urandom}, 4'd8);
		set_search_count(5'd31);
		send_frame(29'h1FFF_FFFF, {$urandom, $urandom}, 4'd8);
	endtask

	// Mostly frames that hit loaded messages, mixed with table rewrites and noise.
	task automatic test_random_traffic(int n);
		logic [4:0] counts[6] = '{5'd16, 5'd0, 5'd1, 5'd8, 5'd31, 5'd17};
		int limit, ms, pick;
		for (int k = 0; k < n; k++) begin
			if (k % 60 == 59)
				set_search_count(counts[$urandom_range(0, 5)]);
			if (k % 25 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			limit = (search_count > MESSAGE_SLOTS) ? MESSAGE_SLOTS : search_count;
			pick = $urandom_range(0, 99);
			ms = $urandom_range(0, MESSAGE_SLOTS - 1);
			if (pick < 55 && limit > 0)
				send_frame(slot_id[$urandom_range(0, limit - 1)], {$urandom, $urandom},
					($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd8);
			else if (pick < 65)
				send_frame(29'($urandom), {$urandom, $urandom}, 4'($urandom));
			else if (pick < 75)
				write_message(ms, ($urandom_range(0, 1) == 0) ? slot_id[ms] : 29'($urandom),
					4'($urandom_range(0, 15)));
			else if (pick < 88)
				write_random_signal(ms, $urandom_range(0, SIGNALS_PER_MESSAGE - 1));
			else
				write_event(ms, $urandom_range(0, SIGNALS_PER_MESSAGE - 1),
					$urandom_range(0, EVENTS_PER_SIGNAL - 1), 10'($urandom), pick_value());
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Receiver holds off while frames keep coming, so the input side backs up.
	task automatic test_backpressure();
		set_search_count(5'd16);
		rx_hold = 800;
		for (int k = 0; k < 12; k++)
			send_frame(slot_id[$urandom_range(0, MESSAGE_SLOTS - 1)], {$urandom, $urandom},
				4'd8);
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_table_load();
		test_directed_decode();
		test_random_traffic(80);
		test_backpressure();
		drain();
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		$display("Sent %0d items (%0d frames); checked %0d results, %0d of them events.",
			items_sent, frames_sent, results_seen, events_seen);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: can_signal_decode_event_match_unit.f
design/csdem_pkg.sv
design/can_signal_decode_event_match_unit.sv
test/can_signal_decode_event_match_unit_tb.sv
